### hdl/wavpcm_pkg.sv
// shared types and constants for the riff/wave pcm stream decoder
// no dependencies
package wavpcm_pkg;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FMT, PH_SKIP,
    PH_DATA, PH_TAIL, PH_DONE, PH_DEAD
  } phase_t;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_BAD_RIFF  = 3'd0;
  localparam logic [2:0] ERR_BAD_WAVE  = 3'd1;
  localparam logic [2:0] ERR_FMT_SHORT = 3'd2;
  localparam logic [2:0] ERR_NO_DATA   = 3'd3;
  localparam logic [2:0] ERR_INVALID   = 3'd4;
  localparam logic [2:0] ERR_ALIGN     = 3'd5;
  localparam logic [2:0] ERR_TRUNC     = 3'd6;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_RF64 = 32'h3436_4652;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] FMT_IEEE       = 16'd3;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        isf;
    logic [15:0] chan;
    logic        fe;
    logic [2:0]  err;
    logic [31:0] rate;
    logic [15:0] ctot;
    logic [15:0] sbits;
    logic [15:0] ftag;
    logic        last;
  } res_t;

  // guid bytes after the leading format byte
  function automatic logic [7:0] guid_tail(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd5:  r = 8'h10;
      4'd7:  r = 8'h80;
      4'd10: r = 8'hAA;
      4'd12: r = 8'h38;
      4'd13: r = 8'h9B;
      4'd14: r = 8'h71;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### hdl/wavpcm_conv.sv
// sample formatter: turns gathered little-endian bytes into q1.31 or raw float bits
// depends on wavpcm_pkg
module wavpcm_conv import wavpcm_pkg::*; (
  input  logic [31:0] accum,
  input  logic [15:0] depth,
  input  logic [15:0] fmt,
  output logic [31:0] value,
  output logic        isf
);
  always_comb begin
    isf = 1'b0;
    if (fmt == FMT_IEEE && depth == 16'd32) begin
      value = accum;
      isf = 1'b1;
    end else if (depth == 16'd8) begin
      value = {~accum[7], accum[6:0], 24'd0};
    end else if (depth == 16'd16) begin
      value = {accum[15:0], 16'd0};
    end else if (depth == 16'd24) begin
      value = {accum[23:0], 8'd0};
    end else if (depth == 16'd32) begin
      value = accum;
    end else begin
      value = 32'd0;
    end
  end
endmodule

### hdl/wav_stream_pcm_decoder_core.sv
// top level of the riff/wave pcm stream decoder
// depends on wavpcm_pkg and wavpcm_conv
//
// Takes one file byte per cycle while s_tready is high, decoding it in a single registered
// pass; each byte gives at most two results (a sample or header plus an end-of-file error).
// Results sit in a two-entry output register drained one per cycle while m_tready is high;
// the input stalls while two results wait or one waits with m_tready low. tlast on the
// input marks the final byte of a file, after which the parser returns to its reset state.
module wav_stream_pcm_decoder_core import wavpcm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // stream_end
  output logic         m_tvalid,
  input  logic         m_tready,
  // sample_value, channel_index, frame_end, error_code, rate_hz, channel_total,
  // sample_bits, format_tag, zero pad
  output logic [135:0] m_tdata,
  output logic [2:0]   m_tuser,   // result_kind, is_float
  output logic         m_tlast    // run_last
);

  phase_t      phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [32:0] skip_left, skip_left_next;
  logic [15:0] fmt_code, fmt_code_next;
  logic [15:0] chan_count, chan_count_next;
  logic [31:0] rate_reg, rate_reg_next;
  logic [15:0] frame_bytes, frame_bytes_next;
  logic [15:0] depth_bits, depth_bits_next;
  logic [1:0]  guid_match, guid_match_next;
  logic        fmt_ok, fmt_ok_next;
  logic [31:0] data_rem, data_rem_next;
  logic [31:0] sample_accum, sample_accum_next;
  logic [12:0] byte_in_sample, byte_in_sample_next;
  logic [15:0] cur_chan, cur_chan_next;

  res_t        slot0, slot1;
  logic [1:0]  cnt;
  res_t        r0, r1;
  logic [1:0]  n;

  logic        accept, pop;
  logic [7:0]  b;
  logic [31:0] acc_merged;
  logic [31:0] conv_value;
  logic        conv_isf;
  logic [12:0] bps;
  logic [28:0] align_prod;
  logic [31:0] len;
  logic [31:0] k;
  logic [12:0] bis_inc;
  logic [16:0] chan_inc;

  assign b = s_tdata;
  assign bps = depth_bits[15:3];
  assign align_prod = chan_count * bps;
  assign pop = m_tvalid && m_tready;
  assign s_tready = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);
  assign accept = s_tvalid && s_tready;

  // accumulator with the incoming byte placed in its lane
  always_comb begin
    acc_merged = sample_accum;
    if (byte_in_sample < 13'd4) begin
      case (byte_in_sample[1:0])
        2'd0: acc_merged[7:0] = b;
        2'd1: acc_merged[15:8] = b;
        2'd2: acc_merged[23:16] = b;
        default: acc_merged[31:24] = b;
      endcase
    end
  end

  wavpcm_conv u_conv (
    .accum (acc_merged),
    .depth (depth_bits),
    .fmt   (fmt_code),
    .value (conv_value),
    .isf   (conv_isf)
  );

  function automatic res_t mk(input logic [1:0] kind, input logic [2:0] err);
    res_t r;
    r = '0;
    r.kind = kind;
    r.err = err;
    return r;
  endfunction

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    tag_shift_next = tag_shift;
    chunk_length_next = chunk_length;
    skip_left_next = skip_left;
    fmt_code_next = fmt_code;
    chan_count_next = chan_count;
    rate_reg_next = rate_reg;
    frame_bytes_next = frame_bytes;
    depth_bits_next = depth_bits;
    guid_match_next = guid_match;
    fmt_ok_next = fmt_ok;
    data_rem_next = data_rem;
    sample_accum_next = sample_accum;
    byte_in_sample_next = byte_in_sample;
    cur_chan_next = cur_chan;
    r0 = '0;
    r1 = '0;
    n = 2'd0;
    len = {b, chunk_length[31:8]};
    k = byte_count;
    bis_inc = byte_in_sample + 13'd1;
    chan_inc = {1'b0, cur_chan} + 17'd1;

    case (phase)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID: begin
        tag_shift_next = {b, tag_shift[31:8]};
        byte_count_next = byte_count + 32'd1;
        if (byte_count_next >= 32'd4) begin
          byte_count_next = '0;
          case (phase)
            PH_RIFF: begin
              if (tag_shift_next != TAG_RIFF && tag_shift_next != TAG_RF64) begin
                r0 = mk(KIND_ERROR, ERR_BAD_RIFF); n = 2'd1; phase_next = PH_DEAD;
              end else phase_next = PH_RSIZE;
            end
            PH_RSIZE: phase_next = PH_WAVE;
            PH_WAVE: begin
              if (tag_shift_next != TAG_WAVE) begin
                r0 = mk(KIND_ERROR, ERR_BAD_WAVE); n = 2'd1; phase_next = PH_DEAD;
              end else phase_next = PH_CID;
            end
            default: phase_next = PH_CSIZE;
          endcase
        end
      end
      PH_CSIZE: begin
        chunk_length_next = len;
        byte_count_next = byte_count + 32'd1;
        if (byte_count_next >= 32'd4) begin
          byte_count_next = '0;
          if (tag_shift == TAG_FMT) begin
            if (len < 32'd16) begin
              r0 = mk(KIND_ERROR, ERR_FMT_SHORT); n = 2'd1; phase_next = PH_DEAD;
            end else begin
              guid_match_next = 2'b11;
              phase_next = PH_FMT;
            end
          end else if (tag_shift == TAG_DATA) begin
            if (!fmt_ok || frame_bytes == 16'd0) begin
              r0 = mk(KIND_ERROR, ERR_INVALID); n = 2'd1; phase_next = PH_DEAD;
            end else if (len == 32'd0) begin
              r0 = mk(KIND_ERROR, ERR_NO_DATA); n = 2'd1; phase_next = PH_DEAD;
            end else if (bps == 13'd0 || {13'd0, frame_bytes} != align_prod) begin
              r0 = mk(KIND_ERROR, ERR_ALIGN); n = 2'd1; phase_next = PH_DEAD;
            end else begin
              r0 = mk(KIND_HEADER, ERR_BAD_RIFF);
              r0.rate = rate_reg;
              r0.ctot = chan_count;
              r0.sbits = depth_bits;
              r0.ftag = fmt_code;
              n = 2'd1;
              data_rem_next = len;
              sample_accum_next = '0;
              byte_in_sample_next = '0;
              cur_chan_next = '0;
              phase_next = PH_DATA;
            end
          end else begin
            skip_left_next = {1'b0, len} + {32'd0, len[0]};
            phase_next = (skip_left_next != 33'd0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_FMT: begin
        if (k < 32'd2) begin
          if (k[0]) fmt_code_next[15:8] = b; else fmt_code_next[7:0] = b;
        end else if (k < 32'd4) begin
          if (k[0]) chan_count_next[15:8] = b; else chan_count_next[7:0] = b;
        end else if (k < 32'd8) begin
          case (k[1:0])
            2'd0: rate_reg_next[7:0] = b;
            2'd1: rate_reg_next[15:8] = b;
            2'd2: rate_reg_next[23:16] = b;
            default: rate_reg_next[31:24] = b;
          endcase
        end else if (k == 32'd12 || k == 32'd13) begin
          if (k[0]) frame_bytes_next[15:8] = b; else frame_bytes_next[7:0] = b;
        end else if (k == 32'd14 || k == 32'd15) begin
          if (k[0]) depth_bits_next[15:8] = b; else depth_bits_next[7:0] = b;
        end else if (k >= 32'd24 && k < 32'd40) begin
          if (k[3:0] == 4'd8) begin
            if (b != 8'h01) guid_match_next[0] = 1'b0;
            if (b != 8'h03) guid_match_next[1] = 1'b0;
          end else if (b != guid_tail(k[3:0] - 4'd9)) begin
            guid_match_next = 2'b00;
          end
        end
        byte_count_next = byte_count + 32'd1;
        if (byte_count_next == chunk_length) begin
          if (fmt_code_next == FMT_EXTENSIBLE && chunk_length >= 32'd40) begin
            if (guid_match_next[0]) fmt_code_next = FMT_PCM;
            else if (guid_match_next[1]) fmt_code_next = FMT_IEEE;
          end
          fmt_ok_next = chan_count_next != 16'd0 && rate_reg_next != 32'd0 &&
                        frame_bytes_next != 16'd0 && depth_bits_next != 16'd0;
          byte_count_next = '0;
          if (chunk_length[0]) begin
            skip_left_next = 33'd1;
            phase_next = PH_SKIP;
          end else phase_next = PH_CID;
        end
      end
      PH_SKIP: begin
        if (skip_left != 33'd0) skip_left_next = skip_left - 33'd1;
        if (skip_left_next == 33'd0) begin
          phase_next = PH_CID;
          byte_count_next = '0;
        end
      end
      PH_DATA: begin
        data_rem_next = data_rem - 32'd1;
        if (byte_in_sample == 13'd0 && cur_chan == 16'd0 &&
            data_rem < {16'd0, frame_bytes}) begin
          phase_next = PH_TAIL;
        end else begin
          sample_accum_next = acc_merged;
          byte_in_sample_next = bis_inc;
          if (bis_inc >= bps) begin
            r0 = mk(KIND_SAMPLE, ERR_BAD_RIFF);
            r0.value = conv_value;
            r0.isf = conv_isf;
            r0.chan = cur_chan;
            r0.fe = chan_inc >= {1'b0, chan_count};
            n = 2'd1;
            cur_chan_next = r0.fe ? 16'd0 : chan_inc[15:0];
            sample_accum_next = '0;
            byte_in_sample_next = '0;
          end
        end
        if (data_rem_next == 32'd0) phase_next = PH_DONE;
      end
      PH_TAIL: begin
        data_rem_next = data_rem - 32'd1;
        if (data_rem_next == 32'd0) phase_next = PH_DONE;
      end
      default: ;
    endcase

    if (s_tlast) begin
      case (phase_next)
        PH_RIFF, PH_RSIZE: begin
          if (n == 2'd0) r0 = mk(KIND_ERROR, ERR_BAD_RIFF); else r1 = mk(KIND_ERROR, ERR_BAD_RIFF);
          n = n + 2'd1;
        end
        PH_WAVE: begin
          if (n == 2'd0) r0 = mk(KIND_ERROR, ERR_BAD_WAVE); else r1 = mk(KIND_ERROR, ERR_BAD_WAVE);
          n = n + 2'd1;
        end
        PH_CID, PH_CSIZE, PH_SKIP: begin
          if (n == 2'd0) r0 = mk(KIND_ERROR, ERR_NO_DATA); else r1 = mk(KIND_ERROR, ERR_NO_DATA);
          n = n + 2'd1;
        end
        PH_FMT, PH_DATA, PH_TAIL: begin
          if (n == 2'd0) r0 = mk(KIND_ERROR, ERR_TRUNC); else r1 = mk(KIND_ERROR, ERR_TRUNC);
          n = n + 2'd1;
        end
        default: ;
      endcase
      phase_next = PH_RIFF;
      byte_count_next = '0;
      tag_shift_next = '0;
      chunk_length_next = '0;
      skip_left_next = '0;
      fmt_code_next = '0;
      chan_count_next = '0;
      rate_reg_next = '0;
      frame_bytes_next = '0;
      depth_bits_next = '0;
      guid_match_next = 2'b11;
      fmt_ok_next = 1'b0;
      data_rem_next = '0;
      sample_accum_next = '0;
      byte_in_sample_next = '0;
      cur_chan_next = '0;
    end

    if (n == 2'd1) r0.last = 1'b1;
    else if (n == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
      byte_count <= '0;
      tag_shift <= '0;
      chunk_length <= '0;
      skip_left <= '0;
      fmt_code <= '0;
      chan_count <= '0;
      rate_reg <= '0;
      frame_bytes <= '0;
      depth_bits <= '0;
      guid_match <= 2'b11;
      fmt_ok <= 1'b0;
      data_rem <= '0;
      sample_accum <= '0;
      byte_in_sample <= '0;
      cur_chan <= '0;
    end else if (accept) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      tag_shift <= tag_shift_next;
      chunk_length <= chunk_length_next;
      skip_left <= skip_left_next;
      fmt_code <= fmt_code_next;
      chan_count <= chan_count_next;
      rate_reg <= rate_reg_next;
      frame_bytes <= frame_bytes_next;
      depth_bits <= depth_bits_next;
      guid_match <= guid_match_next;
      fmt_ok <= fmt_ok_next;
      data_rem <= data_rem_next;
      sample_accum <= sample_accum_next;
      byte_in_sample <= byte_in_sample_next;
      cur_chan <= cur_chan_next;
    end
  end

  // two-entry result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign m_tvalid = cnt != 2'd0;
  assign m_tdata = {4'd0, slot0.ftag, slot0.sbits, slot0.ctot, slot0.rate, slot0.err,
                    slot0.fe, slot0.chan, slot0.value};
  assign m_tuser = {slot0.isf, slot0.kind};
  assign m_tlast = slot0.last;

endmodule

### dv/wav_stream_pcm_decoder_core_test.sv
// self-checking testbench for wav_stream_pcm_decoder_core: byte-wise riff/wave files in,
// header, sample and error items out, compared with an in-bench decoder model
// depends on wavpcm_pkg and the decoder rtl
module wav_stream_pcm_decoder_core_test;
  import wavpcm_pkg::*;

  localparam int WDOG_LIMIT = 3000;

  typedef struct {
    logic [7:0] b;
    logic       fin;
  } byte_t;

  typedef struct {
    logic [7:0] b;
    logic       fin;
    bit         chk;
    logic [2:0] err;
  } row_t;

  localparam logic [7:0] GUID_REST [15] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00,
    8'h80, 8'h00, 8'h00, 8'hAA, 8'h00, 8'h38, 8'h9B, 8'h71
  };

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [135:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  wav_stream_pcm_decoder_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // decoder model state
  phase_t      phase;
  logic [31:0] cnt, tag_sr, chunk_len, data_cnt, acc;
  logic [32:0] skip_cnt;
  logic [15:0] fcode, nchan, align, bits, cur_ch;
  logic [31:0] srate;
  logic [1:0]  guid_ok;
  logic        fmt_valid;
  logic [12:0] bis;

  res_t        step_res [2];
  int          step_n;
  res_t        pending [$];
  byte_t       stim [$];
  int          errs = 0;
  int          sent = 0;
  int          idle_cycles = 0;

  function automatic void model_reset();
    phase = PH_RIFF; cnt = 0; tag_sr = 0; chunk_len = 0; skip_cnt = 0;
    fcode = 0; nchan = 0; srate = 0; align = 0; bits = 0; guid_ok = 2'b11;
    fmt_valid = 0; data_cnt = 0; acc = 0; bis = 0; cur_ch = 0;
  endfunction

  function automatic void add_res(logic [1:0] kind, logic [31:0] v, logic isf,
                                  logic [15:0] ch, logic fe, logic [2:0] err, bit hdr);
    res_t t;
    if (step_n >= 2) return;
    t = '0;
    t.kind = kind; t.value = v; t.isf = isf; t.chan = ch; t.fe = fe; t.err = err;
    if (hdr) begin
      t.rate = srate; t.ctot = nchan; t.sbits = bits; t.ftag = fcode;
    end
    step_res[step_n] = t;
    step_n++;
  endfunction

  function automatic void set_error(logic [2:0] code);
    add_res(KIND_ERROR, 0, 0, 0, 0, code, 0);
    phase = PH_DEAD;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin);
    logic [31:0] k, bps, whole, v;
    logic        isf, fe;
    step_n = 0;
    case (phase)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID: begin
        tag_sr = {b, tag_sr[31:8]};
        cnt++;
        if (cnt >= 4) begin
          cnt = 0;
          if (phase == PH_RIFF) begin
            if (tag_sr != TAG_RIFF && tag_sr != TAG_RF64) set_error(ERR_BAD_RIFF);
            else phase = PH_RSIZE;
          end else if (phase == PH_RSIZE) begin
            phase = PH_WAVE;
          end else if (phase == PH_WAVE) begin
            if (tag_sr != TAG_WAVE) set_error(ERR_BAD_WAVE);
            else phase = PH_CID;
          end else begin
            phase = PH_CSIZE;
          end
        end
      end
      PH_CSIZE: begin
        chunk_len = {b, chunk_len[31:8]};
        cnt++;
        if (cnt >= 4) begin
          cnt = 0;
          if (tag_sr == TAG_FMT) begin
            if (chunk_len < 16) set_error(ERR_FMT_SHORT);
            else begin
              guid_ok = 2'b11;
              phase = PH_FMT;
            end
          end else if (tag_sr == TAG_DATA) begin
            bps = bits / 8;
            if (!fmt_valid || align == 0) set_error(ERR_INVALID);
            else if (chunk_len == 0) set_error(ERR_NO_DATA);
            else if (bps == 0 || 32'(align) != 32'(nchan) * bps) set_error(ERR_ALIGN);
            else begin
              add_res(KIND_HEADER, 0, 0, 0, 0, 0, 1);
              whole = (chunk_len / align) * align;
              data_cnt = whole;
              skip_cnt = 33'(chunk_len - whole);
              acc = 0; bis = 0; cur_ch = 0;
              phase = (whole != 0) ? PH_DATA : ((skip_cnt != 0) ? PH_TAIL : PH_DONE);
            end
          end else begin
            skip_cnt = 33'(chunk_len) + 33'(chunk_len[0]);
            phase = (skip_cnt != 0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_FMT: begin
        k = cnt;
        if (k < 2) fcode[8*k[0] +: 8] = b;
        else if (k < 4) nchan[8*(k[0]) +: 8] = b;
        else if (k < 8) srate[8*(k[1:0]) +: 8] = b;
        else if (k == 12 || k == 13) align[8*k[0] +: 8] = b;
        else if (k == 14 || k == 15) bits[8*k[0] +: 8] = b;
        else if (k >= 24 && k < 40) begin
          if (k == 24) begin
            if (b != 8'h01) guid_ok[0] = 0;
            if (b != 8'h03) guid_ok[1] = 0;
          end else if (b != GUID_REST[k - 25]) begin
            guid_ok = 0;
          end
        end
        cnt++;
        if (cnt == chunk_len) begin
          if (fcode == FMT_EXTENSIBLE && chunk_len >= 40) begin
            if (guid_ok[0]) fcode = FMT_PCM;
            else if (guid_ok[1]) fcode = FMT_IEEE;
          end
          fmt_valid = (nchan != 0 && srate != 0 && align != 0 && bits != 0);
          cnt = 0;
          if (chunk_len[0]) begin
            skip_cnt = 1; phase = PH_SKIP;
          end else begin
            phase = PH_CID;
          end
        end
      end
      PH_SKIP: begin
        if (skip_cnt != 0) skip_cnt--;
        if (skip_cnt == 0) begin
          phase = PH_CID; cnt = 0;
        end
      end
      PH_DATA: begin
        bps = bits / 8;
        if (bis < 4) acc[8*bis[1:0] +: 8] = b;
        bis++;
        data_cnt--;
        if (32'(bis) >= bps) begin
          isf = 0;
          if (fcode == FMT_IEEE && bits == 32) begin
            v = acc; isf = 1;
          end else if (bits == 8) v = {acc[7:0] ^ 8'h80, 24'd0};
          else if (bits == 16) v = {acc[15:0], 16'd0};
          else if (bits == 24) v = {acc[23:0], 8'd0};
          else if (bits == 32) v = acc;
          else v = 0;
          fe = (32'(cur_ch) + 1 >= 32'(nchan));
          add_res(KIND_SAMPLE, v, isf, cur_ch, fe, 0, 0);
          cur_ch = fe ? 16'd0 : cur_ch + 16'd1;
          acc = 0; bis = 0;
        end
        if (data_cnt == 0) phase = (skip_cnt != 0) ? PH_TAIL : PH_DONE;
      end
      PH_TAIL: begin
        if (skip_cnt != 0) skip_cnt--;
        if (skip_cnt == 0) phase = PH_DONE;
      end
      default: ;
    endcase
    if (fin) begin
      case (phase)
        PH_RIFF, PH_RSIZE: add_res(KIND_ERROR, 0, 0, 0, 0, ERR_BAD_RIFF, 0);
        PH_WAVE: add_res(KIND_ERROR, 0, 0, 0, 0, ERR_BAD_WAVE, 0);
        PH_CID, PH_CSIZE, PH_SKIP: add_res(KIND_ERROR, 0, 0, 0, 0, ERR_NO_DATA, 0);
        PH_FMT, PH_DATA, PH_TAIL: add_res(KIND_ERROR, 0, 0, 0, 0, ERR_TRUNC, 0);
        default: ;
      endcase
      model_reset();
    end
    if (step_n > 0) step_res[step_n - 1].last = 1;
    for (int i = 0; i < step_n; i++) pending.push_back(step_res[i]);
  endfunction

  // stimulus construction
  function automatic void put_le(logic [31:0] v, int nb);
    byte_t t;
    for (int i = 0; i < nb; i++) begin
      t.b = v[8*i +: 8]; t.fin = 0;
      stim.push_back(t);
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void make_file();
    int          first, r, nfmt, fsize, frames, dlen, cut;
    logic [15:0] ftag, ch, depth, blk;
    logic [7:0]  body [40];
    logic [31:0] cid;
    first = stim.size();
    r = $urandom_range(0, 99);
    put_le((r < 4) ? $urandom : ($urandom_range(0, 1) ? TAG_RF64 : TAG_RIFF), 4);
    put_le($urandom, 4);
    put_le((r >= 4 && r < 8) ? $urandom : TAG_WAVE, 4);
    if ($urandom_range(0, 3) == 0) begin
      cid = $urandom;
      fsize = $urandom_range(0, 9);
      put_le(cid, 4); put_le(fsize, 4);
      for (int i = 0; i < fsize + (fsize & 1); i++) put_le(pick_byte(), 1);
    end
    nfmt = (r >= 8 && r < 11) ? 0 : (($urandom_range(0, 7) == 0) ? 2 : 1);
    ch = 1; depth = 16; blk = 2;
    for (int f = 0; f < nfmt; f++) begin
      case ($urandom_range(0, 9))
        0, 1: depth = 8;
        2, 3: depth = 16;
        4, 5: depth = 24;
        6, 7: depth = 32;
        8: depth = 12;
        default: depth = $urandom_range(0, 7);
      endcase
      ch = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      blk = ch * (depth / 8);
      if ($urandom_range(0, 11) == 0) blk = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0, 1, 2: ftag = FMT_PCM;
        3, 4: ftag = FMT_IEEE;
        5, 6, 7, 8: ftag = FMT_EXTENSIBLE;
        default: ftag = $urandom;
      endcase
      if (ftag == FMT_EXTENSIBLE) fsize = $urandom_range(0, 3) ? 40 : 41;
      else fsize = ($urandom_range(0, 2) == 0) ? 17 + $urandom_range(0, 1) : 16;
      if ($urandom_range(0, 14) == 0) fsize = $urandom_range(0, 15);
      for (int i = 0; i < 40; i++) body[i] = pick_byte();
      {body[1], body[0]} = ftag;
      {body[3], body[2]} = ch;
      {body[7], body[6], body[5], body[4]} = ($urandom_range(0, 19) == 0) ? 0 : $urandom;
      {body[13], body[12]} = blk;
      {body[15], body[14]} = depth;
      body[24] = $urandom_range(0, 4) ? ($urandom_range(0, 1) ? 8'h01 : 8'h03) : pick_byte();
      for (int i = 0; i < 15; i++) body[25 + i] = GUID_REST[i];
      if ($urandom_range(0, 5) == 0) body[$urandom_range(25, 39)] = pick_byte();
      put_le(TAG_FMT, 4); put_le(fsize, 4);
      for (int i = 0; i < fsize; i++) put_le((i < 40) ? body[i] : pick_byte(), 1);
      if (fsize >= 16 && fsize[0]) put_le(pick_byte(), 1);
    end
    frames = $urandom_range(0, 8);
    dlen = frames * ((blk != 0) ? blk : 1);
    if ($urandom_range(0, 3) == 0) dlen += $urandom_range(1, 3);
    if ($urandom_range(0, 24) == 0) dlen = 0;
    put_le(TAG_DATA, 4); put_le(dlen, 4);
    for (int i = 0; i < dlen; i++) put_le(pick_byte(), 1);
    for (int i = $urandom_range(0, 3); i > 0; i--) put_le(pick_byte(), 1);
    if ($urandom_range(0, 5) == 0) begin
      cut = first + $urandom_range(1, stim.size() - first);
      while (stim.size() > cut) void'(stim.pop_back());
    end
    stim[stim.size() - 1].fin = 1;
  endfunction

  row_t dir_tab [$] = '{
    '{"R", 0, 0, 0}, '{"I", 0, 0, 0}, '{"F", 0, 0, 0},
    '{"X", 1, 1, ERR_BAD_RIFF},
    '{"R", 1, 1, ERR_BAD_RIFF},
    '{"R", 0, 0, 0}, '{"F", 0, 0, 0}, '{"6", 0, 0, 0}, '{"4", 0, 0, 0},
    '{8'hFF, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'hFF, 0, 0, 0},
    '{"W", 0, 0, 0}, '{"A", 0, 0, 0}, '{"V", 0, 0, 0},
    '{"X", 1, 1, ERR_BAD_WAVE},
    '{"R", 0, 0, 0}, '{"I", 0, 0, 0}, '{"F", 0, 0, 0}, '{"F", 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{"W", 0, 0, 0},
    '{"A", 1, 1, ERR_BAD_WAVE}
  };

  // sender
  initial begin
    byte_t t;
    int    i;
    model_reset();
    foreach (dir_tab[j]) begin
      t.b = dir_tab[j].b; t.fin = dir_tab[j].fin;
      stim.push_back(t);
    end
    while (stim.size() < 1300) make_file();
    repeat (5) @(posedge clk);
    rst <= 0;
    i = 0;
    while (i < stim.size()) begin
      if (i < stim.size() - 150 && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      s_tvalid <= 1;
      s_tdata <= stim[i].b;
      s_tlast <= stim[i].fin;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      decode_byte(stim[i].b, stim[i].fin);
      if (i < dir_tab.size() && dir_tab[i].chk) begin
        if (step_n == 0 || step_res[step_n - 1].kind != KIND_ERROR ||
            step_res[step_n - 1].err != dir_tab[i].err) begin
          $display("%0t error item expected code %0d, model gave %0d results", $time,
                   dir_tab[i].err, step_n);
          errs++;
        end
      end
      i++;
      sent = i;
    end
    s_tvalid <= 0;
    s_tlast <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending.size() != 0) errs++;
    if (errs == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver with random stalls and one long hold-off
  int  hold = 0;
  bit  held_long = 0;
  always @(posedge clk) begin
    if (!held_long && sent >= 400) begin
      held_long = 1;
      hold = 80;
    end
    if (hold > 0) begin
      hold--;
      m_tready <= 0;
    end else if (sent < stim.size() - 150 && $urandom_range(0, 4) == 0) begin
      hold = $urandom_range(0, 6);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  function automatic void cmp_field(string nm, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      $display("%0t %s expected %h actual %h", $time, nm, e, g);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected item expected none actual %h %h", $time, m_tuser, m_tdata);
        errs++;
      end else begin
        e = pending.pop_front();
        cmp_field("result_kind", e.kind, m_tuser[1:0]);
        cmp_field("is_float", e.isf, m_tuser[2]);
        cmp_field("sample_value", e.value, m_tdata[31:0]);
        cmp_field("channel_index", e.chan, m_tdata[47:32]);
        cmp_field("frame_end", e.fe, m_tdata[48]);
        cmp_field("error_code", e.err, m_tdata[51:49]);
        cmp_field("rate_hz", e.rate, m_tdata[83:52]);
        cmp_field("channel_total", e.ctot, m_tdata[99:84]);
        cmp_field("sample_bits", e.sbits, m_tdata[115:100]);
        cmp_field("format_tag", e.ftag, m_tdata[131:116]);
        cmp_field("run_last", e.last, m_tlast);
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### wav_stream_pcm_decoder_core.f
hdl/wavpcm_pkg.sv
hdl/wavpcm_conv.sv
hdl/wav_stream_pcm_decoder_core.sv
dv/wav_stream_pcm_decoder_core_test.sv
